### hw/rtl/lle_pkg.sv
// ----------------------------------------------------------------------------
// lle_pkg
// Shared types and codes of the LAPDm link engine.
// ----------------------------------------------------------------------------
package lle_pkg;

  localparam int unsigned TIMER_BITS  = 16;
  localparam int unsigned MAX_RES     = 8;
  localparam int unsigned INQ_DEPTH   = 2;
  localparam int unsigned OUTQ_DEPTH  = 4;

  // link states
  localparam logic [2:0] ST_REL  = 3'd0;
  localparam logic [2:0] ST_AEST = 3'd1;
  localparam logic [2:0] ST_AREL = 3'd2;
  localparam logic [2:0] ST_EST  = 3'd3;
  localparam logic [2:0] ST_CONT = 3'd4;

  // input commands
  localparam logic [3:0] CMD_FRAME  = 4'd0;
  localparam logic [3:0] CMD_L1EST  = 4'd1;
  localparam logic [3:0] CMD_HO     = 4'd2;
  localparam logic [3:0] CMD_TICK   = 4'd3;
  localparam logic [3:0] CMD_ESTREQ = 4'd4;
  localparam logic [3:0] CMD_RELREQ = 4'd5;
  localparam logic [3:0] CMD_ERR    = 4'd6;
  localparam logic [3:0] CMD_HARD   = 4'd7;
  localparam logic [3:0] CMD_SEG    = 4'd8;

  // classified events
  localparam logic [3:0] EV_RX_I   = 4'd0;
  localparam logic [3:0] EV_RX_S   = 4'd1;
  localparam logic [3:0] EV_RX_U   = 4'd2;
  localparam logic [3:0] EV_L1EST  = 4'd3;
  localparam logic [3:0] EV_HO     = 4'd4;
  localparam logic [3:0] EV_TICK   = 4'd5;
  localparam logic [3:0] EV_ESTREQ = 4'd6;
  localparam logic [3:0] EV_RELREQ = 4'd7;
  localparam logic [3:0] EV_ERR    = 4'd8;
  localparam logic [3:0] EV_HARD   = 4'd9;
  localparam logic [3:0] EV_SEG    = 4'd10;

  localparam logic [1:0] FMT_I = 2'd0;
  localparam logic [1:0] FMT_S = 2'd1;
  localparam logic [1:0] FMT_U = 2'd2;

  localparam logic [2:0] U_SABM = 3'd0;
  localparam logic [2:0] U_DM   = 3'd1;
  localparam logic [2:0] U_UI   = 3'd2;
  localparam logic [2:0] U_DISC = 3'd3;
  localparam logic [2:0] U_UA   = 3'd4;

  localparam logic [1:0] S_RR  = 2'd0;
  localparam logic [1:0] S_REJ = 2'd1;

  localparam logic [2:0] ACT_SEND  = 3'd0;
  localparam logic [2:0] ACT_IND   = 3'd1;
  localparam logic [2:0] ACT_L1REL = 3'd2;
  localparam logic [2:0] ACT_L1ERR = 3'd3;
  localparam logic [2:0] ACT_IDLE  = 3'd4;
  localparam logic [2:0] ACT_RETX  = 3'd5;
  localparam logic [2:0] ACT_BUSY  = 3'd6;

  localparam logic [2:0] FT_I    = 3'd0;
  localparam logic [2:0] FT_RR   = 3'd1;
  localparam logic [2:0] FT_REJ  = 3'd2;
  localparam logic [2:0] FT_SABM = 3'd3;
  localparam logic [2:0] FT_DISC = 3'd4;
  localparam logic [2:0] FT_UA   = 3'd5;
  localparam logic [2:0] FT_DM   = 3'd6;
  localparam logic [2:0] FT_UI   = 3'd7;

  localparam logic [2:0] IND_EST  = 3'd0;
  localparam logic [2:0] IND_SEG  = 3'd1;
  localparam logic [2:0] IND_LAST = 3'd2;
  localparam logic [2:0] IND_UNIT = 3'd3;
  localparam logic [2:0] IND_REL  = 3'd4;
  localparam logic [2:0] IND_ERR  = 3'd5;
  localparam logic [2:0] IND_HO   = 3'd6;
  localparam logic [2:0] IND_HARD = 3'd7;

  localparam logic [2:0] CFG_SAPI    = 3'd0;
  localparam logic [2:0] CFG_SIDE    = 3'd1;
  localparam logic [2:0] CFG_T200    = 3'd2;
  localparam logic [2:0] CFG_N200    = 3'd3;
  localparam logic [2:0] CFG_N201    = 3'd4;

  typedef struct packed {
    logic [3:0]  code;
    logic [1:0]  s_kind;
    logic [2:0]  u_kind;
    logic        poll_final;
    logic        cr;
    logic [2:0]  ns;
    logic [2:0]  nr;
    logic        more;
    logic [5:0]  length;
    logic [15:0] payload_sum;
  } event_t;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] frame_type;
    logic       address_cr;
    logic       poll_final;
    logic [2:0] nr;
    logic [2:0] ns;
    logic [5:0] length;
    logic       more;
    logic       echo;
    logic [2:0] indication;
  } res_t;

  typedef struct packed {
    res_t       r;
    logic [2:0] link_state;
    logic       last;
  } out_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] e;
    logic [3:0]         n;
  } list_t;

  typedef struct packed {
    logic [2:0]            sc;
    logic [2:0]            ac;
    logic [2:0]            rc;
    logic [7:0]            retry;
    logic [TIMER_BITS-1:0] tl;
    logic                  tr;
    logic                  sp;
  } cnt_t;

  function automatic res_t mk(logic [2:0] act, logic [2:0] ft, logic cr, logic pf,
                              logic [2:0] nr, logic [2:0] ns, logic [5:0] len,
                              logic more, logic echo, logic [2:0] ind);
    res_t r;
    r.action = act; r.frame_type = ft; r.address_cr = cr; r.poll_final = pf;
    r.nr = nr; r.ns = ns; r.length = len; r.more = more; r.echo = echo;
    r.indication = ind;
    return r;
  endfunction

  function automatic list_t push(list_t l, res_t r);
    list_t o;
    o = l;
    if (l.n < 4'(MAX_RES)) begin
      o.e[l.n[2:0]] = r;
      o.n = l.n + 4'd1;
    end
    return o;
  endfunction

endpackage

### hw/rtl/lapdm_link_engine.sv
// ----------------------------------------------------------------------------
// lapdm_link_engine
// LAPDm data link engine, window size one, for one service access point.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive the event fields and raise push; the item is
//   taken on an edge where full is low. Frame headers, layer 1 notices, ticks
//   and layer 3 requests all enter here; meaningless codes are dropped.
//   Result side is a queue too: while empty is low the oldest result sits on
//   the *_o ports; raise pop to take it. Each event yields zero to five
//   results, the final one marked by last_o.
//   Configuration goes over cfg_valid_i/cfg_index_i/cfg_data_i; cfg_ready_o
//   is always high. Write only while no event is in flight.
// Timing:
//   An event waits in the input queue until the state engine is free, which
//   then runs it and fills its result buffer; the results leave one per cycle
//   while the result queue is not full. The engine has a single result
//   buffer, so it takes no new event until the last result of the previous
//   one has left; an event without results does not hold it.
// Reset:
//   rst_ni clears the queues, the link state (released) and all counters and
//   loads the default configuration. A stalled receiver fills the result
//   queue, then the engine holds, then the input queue fills and full rises.
// ----------------------------------------------------------------------------
module lapdm_link_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [3:0]  command_i,
  input  logic [1:0]  frame_format_i,
  input  logic [2:0]  u_kind_i,
  input  logic [1:0]  s_kind_i,
  input  logic        poll_final_in_i,
  input  logic        cr_in_i,
  input  logic [2:0]  ns_in_i,
  input  logic [2:0]  nr_in_i,
  input  logic        more_in_i,
  input  logic [5:0]  length_in_i,
  input  logic [15:0] payload_sum_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  action_o,
  output logic [2:0]  frame_type_o,
  output logic        address_cr_o,
  output logic        poll_final_out_o,
  output logic [2:0]  nr_out_o,
  output logic [2:0]  ns_out_o,
  output logic [5:0]  length_out_o,
  output logic        more_out_o,
  output logic        echo_payload_o,
  output logic [2:0]  indication_o,
  output logic [2:0]  link_state_out_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  lle_pkg::event_t ev;
  logic            ev_valid, ev_take;
  lle_pkg::out_t   res, head;
  logic            res_valid, res_full;

  // Registers are always writable.
  assign cfg_ready_o = 1'b1;

  // Front: classify and queue incoming events.
  lle_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .command_i, .frame_format_i, .u_kind_i, .s_kind_i, .poll_final_in_i,
    .cr_in_i, .ns_in_i, .nr_in_i, .more_in_i, .length_in_i, .payload_sum_i,
    .ev_valid_o (ev_valid),
    .ev_o       (ev),
    .ev_take_i  (ev_take)
  );

  // Back: run the link state machine and hand out its result list.
  lle_back u_back (
    .clk_i, .rst_ni,
    .ev_valid_i  (ev_valid),
    .ev_i        (ev),
    .ev_take_o   (ev_take),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i,
    .cfg_data_i,
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  // Result queue decouples the engine from a stalling receiver.
  lle_outq u_outq (
    .clk_i, .rst_ni,
    .wr_i   (res_valid),
    .data_i (res),
    .full_o (res_full),
    .empty,
    .pop,
    .data_o (head)
  );

  assign action_o         = head.r.action;
  assign frame_type_o     = head.r.frame_type;
  assign address_cr_o     = head.r.address_cr;
  assign poll_final_out_o = head.r.poll_final;
  assign nr_out_o         = head.r.nr;
  assign ns_out_o         = head.r.ns;
  assign length_out_o     = head.r.length;
  assign more_out_o       = head.r.more;
  assign echo_payload_o   = head.r.echo;
  assign indication_o     = head.r.indication;
  assign link_state_out_o = head.link_state;
  assign last_o           = head.last;

endmodule

### hw/rtl/lle_front.sv
// ----------------------------------------------------------------------------
// lle_front
// Accept input items, classify them into events, drop meaningless ones, queue.
// ----------------------------------------------------------------------------
module lle_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [3:0]       command_i,
  input  logic [1:0]       frame_format_i,
  input  logic [2:0]       u_kind_i,
  input  logic [1:0]       s_kind_i,
  input  logic             poll_final_in_i,
  input  logic             cr_in_i,
  input  logic [2:0]       ns_in_i,
  input  logic [2:0]       nr_in_i,
  input  logic             more_in_i,
  input  logic [5:0]       length_in_i,
  input  logic [15:0]      payload_sum_i,
  output logic             ev_valid_o,
  output lle_pkg::event_t  ev_o,
  input  logic             ev_take_i
);

  lle_pkg::event_t q_mem [lle_pkg::INQ_DEPTH];
  logic            wp_q, wp_d, rp_q, rp_d;
  logic [1:0]      cnt_q, cnt_d;
  lle_pkg::event_t ev;
  logic            keep, wr;

  always_comb begin
    keep = 1'b1;
    ev.code = lle_pkg::EV_RX_I;
    case (command_i)
      lle_pkg::CMD_FRAME: begin
        case (frame_format_i)
          lle_pkg::FMT_I: ev.code = lle_pkg::EV_RX_I;
          lle_pkg::FMT_S: ev.code = lle_pkg::EV_RX_S;
          lle_pkg::FMT_U: ev.code = lle_pkg::EV_RX_U;
          default:        keep = 1'b0;
        endcase
      end
      lle_pkg::CMD_L1EST:  ev.code = lle_pkg::EV_L1EST;
      lle_pkg::CMD_HO:     ev.code = lle_pkg::EV_HO;
      lle_pkg::CMD_TICK:   ev.code = lle_pkg::EV_TICK;
      lle_pkg::CMD_ESTREQ: ev.code = lle_pkg::EV_ESTREQ;
      lle_pkg::CMD_RELREQ: ev.code = lle_pkg::EV_RELREQ;
      lle_pkg::CMD_ERR:    ev.code = lle_pkg::EV_ERR;
      lle_pkg::CMD_HARD:   ev.code = lle_pkg::EV_HARD;
      lle_pkg::CMD_SEG:    ev.code = lle_pkg::EV_SEG;
      default:             keep = 1'b0;
    endcase
    ev.s_kind      = s_kind_i;
    ev.u_kind      = u_kind_i;
    ev.poll_final  = poll_final_in_i;
    ev.cr          = cr_in_i;
    ev.ns          = ns_in_i;
    ev.nr          = nr_in_i;
    ev.more        = more_in_i;
    ev.length      = length_in_i;
    ev.payload_sum = payload_sum_i;
  end

  assign full       = (cnt_q == 2'(lle_pkg::INQ_DEPTH));
  assign wr         = push && !full && keep;
  assign ev_valid_o = (cnt_q != 2'd0);
  assign ev_o       = q_mem[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (wr) begin
      wp_d  = ~wp_q;
      cnt_d = cnt_d + 2'd1;
    end
    if (ev_take_i && ev_valid_o) begin
      rp_d  = ~rp_q;
      cnt_d = cnt_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) q_mem[wp_q] <= ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### hw/rtl/lle_back.sv
// ----------------------------------------------------------------------------
// lle_back
// Link state machine: run one event, build its result list, drain it in order.
// ----------------------------------------------------------------------------
module lle_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             ev_valid_i,
  input  lle_pkg::event_t  ev_i,
  output logic             ev_take_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i,
  output logic             res_valid_o,
  output lle_pkg::out_t    res_o,
  input  logic             res_full_i
);

  localparam logic [lle_pkg::TIMER_BITS-1:0] TIMER_ONE = lle_pkg::TIMER_BITS'(1);

  // configuration
  logic [1:0]  sapi_q;
  logic        side_q;
  logic [15:0] t200_q;
  logic [7:0]  n200_q;
  logic [5:0]  n201_q;

  // link state
  logic [2:0]           ls_q, ls_d;
  logic                 est_q, est_d;
  logic [15:0]          cv_q, cv_d;
  lle_pkg::cnt_t        cn_q, cn_d;
  logic [15:0]          sh_q, sh_d;

  // result buffer
  lle_pkg::list_t       lst, lst_q;
  logic                 busy_q;
  logic [2:0]           idx_q;

  logic                 abn, rel;
  logic [2:0]           rind;
  logic [5:0]           seg_len;
  logic                 seg_more, sh_bit;
  logic [2:0]           sh_ft;
  logic                 rsp;

  assign ev_take_o = !busy_q && ev_valid_i;
  assign rsp       = ~side_q;
  assign sh_ft     = sh_q[2:0];
  assign sh_bit    = sh_q[15];

  always_comb begin
    ls_d  = ls_q;
    est_d = est_q;
    cv_d  = cv_q;
    cn_d  = cn_q;
    sh_d  = sh_q;
    lst   = '0;
    abn   = 1'b0;
    rel   = 1'b0;
    rind  = lle_pkg::IND_REL;
    seg_len  = ev_i.length;
    seg_more = ev_i.more;
    if (ev_take_o) begin
      case (ev_i.code)
        lle_pkg::EV_RX_I: begin
          est_d = 1'b0;
          if (ls_d == lle_pkg::ST_CONT) ls_d = lle_pkg::ST_EST;
          if (ls_d == lle_pkg::ST_EST) begin
            cn_d.ac = ev_i.nr;
            if (cn_d.ac == cn_d.sc) begin
              cn_d.retry = '0; cn_d.tr = 1'b0; cn_d.tl = '0;
            end
            if (ev_i.ns == cn_d.rc) begin
              cn_d.rc = cn_d.rc + 3'd1;
              cn_d.sp = ev_i.more;
              lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_IND, 3'd0, 1'b0, 1'b0, 3'd0,
                3'd0, 6'd0, 1'b0, 1'b0, ev_i.more ? lle_pkg::IND_SEG : lle_pkg::IND_LAST));
              lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_RR, rsp,
                ev_i.poll_final, cn_d.rc, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
            end else begin
              lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_REJ, rsp,
                ev_i.poll_final, cn_d.rc, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
            end
          end
        end
        lle_pkg::EV_RX_S: begin
          est_d = 1'b0;
          if (ev_i.s_kind == lle_pkg::S_RR) begin
            if (ls_d == lle_pkg::ST_CONT) ls_d = lle_pkg::ST_EST;
            if (ls_d == lle_pkg::ST_EST) begin
              if (ev_i.cr == side_q && ev_i.poll_final)
                lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_RR, rsp,
                  1'b1, cn_d.rc, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
              cn_d.ac = ev_i.nr;
              if (cn_d.ac == cn_d.sc) begin
                cn_d.retry = '0; cn_d.tr = 1'b0; cn_d.tl = '0;
              end
            end
          end else if (ev_i.s_kind == lle_pkg::S_REJ) begin
            if (ls_d == lle_pkg::ST_CONT) ls_d = lle_pkg::ST_EST;
            if (ls_d == lle_pkg::ST_EST) begin
              cn_d.ac = ev_i.nr;
              if (cn_d.ac == cn_d.sc) begin
                cn_d.retry = '0; cn_d.tr = 1'b0; cn_d.tl = '0;
              end
              if (ev_i.poll_final) begin
                if (ev_i.cr != side_q)
                  lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_RR, rsp,
                    1'b1, cn_d.rc, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
                else abn = 1'b1;
              end
              if (!abn) lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_IDLE, lle_pkg::FT_UI,
                side_q, 1'b0, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
            end
            if (!abn) lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_IDLE, lle_pkg::FT_UI,
              side_q, 1'b0, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
          end else begin
            abn = 1'b1;
          end
        end
        lle_pkg::EV_RX_U: begin
          case (ev_i.u_kind)
            lle_pkg::U_SABM: begin
              if (ev_i.poll_final) begin
                case (ls_q)
                  lle_pkg::ST_REL: begin
                    cn_d  = '0;
                    est_d = 1'b1;
                    lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_IND, 3'd0, 1'b0, 1'b0,
                      3'd0, 3'd0, 6'd0, 1'b0, 1'b0, lle_pkg::IND_EST));
                    if (ev_i.length != 6'd0) begin
                      ls_d = lle_pkg::ST_CONT;
                      cv_d = ev_i.payload_sum;
                      lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_IND, 3'd0, 1'b0, 1'b0,
                        3'd0, 3'd0, 6'd0, 1'b0, 1'b0, lle_pkg::IND_LAST));
                      lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_UA,
                        rsp, 1'b1, 3'd0, 3'd0, ev_i.length, 1'b0, 1'b1, 3'd0));
                    end else begin
                      ls_d = lle_pkg::ST_EST;
                      lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_UA,
                        rsp, 1'b1, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
                    end
                  end
                  lle_pkg::ST_CONT: begin
                    if (ev_i.payload_sum == cv_q) begin
                      ls_d = lle_pkg::ST_EST;
                      lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_UA,
                        rsp, 1'b1, 3'd0, 3'd0, ev_i.length, 1'b0, ev_i.length != 6'd0, 3'd0));
                    end
                  end
                  lle_pkg::ST_AEST:
                    lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_UA,
                      rsp, 1'b1, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
                  lle_pkg::ST_AREL:
                    lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_DM,
                      rsp, 1'b1, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
                  default: begin
                    if (est_q) begin
                      lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_UA,
                        rsp, 1'b1, 3'd0, 3'd0, ev_i.length, 1'b0, ev_i.length != 6'd0, 3'd0));
                    end else if (ev_i.length != 6'd0) begin
                      abn = 1'b1;
                    end else begin
                      lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_UA,
                        rsp, 1'b1, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
                      cn_d = '0;
                    end
                  end
                endcase
              end
            end
            lle_pkg::U_DM: begin
              if (ls_q != lle_pkg::ST_REL && ev_i.poll_final) begin
                cn_d = '0; rel = 1'b1;
              end
            end
            lle_pkg::U_UI: begin
              if (ev_i.length != 6'd0)
                lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_IND, 3'd0, 1'b0, 1'b0,
                  3'd0, 3'd0, 6'd0, 1'b0, 1'b0, lle_pkg::IND_UNIT));
            end
            lle_pkg::U_DISC: begin
              est_d = 1'b0;
              if (ls_q == lle_pkg::ST_AEST) begin
                cn_d = '0; rel = 1'b1;
              end else if (ls_q == lle_pkg::ST_REL) begin
                lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_DM, rsp,
                  ev_i.poll_final, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
                cn_d = '0; rel = 1'b1;
              end else begin
                lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_UA, rsp,
                  ev_i.poll_final, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
                if (ls_q != lle_pkg::ST_AREL) begin
                  cn_d = '0; rel = 1'b1;
                end
              end
            end
            lle_pkg::U_UA: begin
              if (!ev_i.poll_final) begin
                abn = 1'b1;
              end else if (ls_q == lle_pkg::ST_AEST) begin
                cn_d = '0;
                ls_d = lle_pkg::ST_EST;
                lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_IND, 3'd0, 1'b0, 1'b0,
                  3'd0, 3'd0, 6'd0, 1'b0, 1'b0, lle_pkg::IND_EST));
              end else if (ls_q == lle_pkg::ST_AREL) begin
                cn_d = '0; rel = 1'b1;
              end else if (ls_q != lle_pkg::ST_EST) begin
                abn = 1'b1;
              end
            end
            default: abn = 1'b1;
          endcase
        end
        lle_pkg::EV_L1EST: cn_d = '0;
        lle_pkg::EV_HO:
          lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_IND, 3'd0, 1'b0, 1'b0,
            3'd0, 3'd0, 6'd0, 1'b0, 1'b0, lle_pkg::IND_HO));
        lle_pkg::EV_TICK: begin
          if (cn_q.tr) begin
            if (cn_q.tl <= TIMER_ONE) begin
              cn_d.tr = 1'b0;
              cn_d.tl = '0;
              if (ls_q == lle_pkg::ST_AREL) begin
                rel = 1'b1;
              end else if (ls_q == lle_pkg::ST_CONT || ls_q == lle_pkg::ST_EST ||
                           ls_q == lle_pkg::ST_AEST) begin
                if (cn_q.retry > n200_q) begin
                  abn = 1'b1;
                end else begin
                  if (cn_q.retry != 8'hFF) cn_d.retry = cn_q.retry + 8'd1;
                  lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_RETX, sh_ft, side_q,
                    (sh_ft == lle_pkg::FT_I) ? 1'b0 : sh_bit, sh_q[5:3], sh_q[8:6],
                    sh_q[14:9], (sh_ft == lle_pkg::FT_I) ? sh_bit : 1'b0, 1'b0, 3'd0));
                  cn_d.tl = t200_q[lle_pkg::TIMER_BITS-1:0];
                  cn_d.tr = 1'b1;
                end
              end
            end else begin
              cn_d.tl = cn_q.tl - TIMER_ONE;
            end
          end
        end
        lle_pkg::EV_ESTREQ: begin
          if (ls_q != lle_pkg::ST_EST) begin
            cn_d = '0;
            ls_d = lle_pkg::ST_AEST;
            sh_d = {1'b1, 6'd0, 3'd0, 3'd0, lle_pkg::FT_SABM};
            lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_SABM, side_q,
              1'b1, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
            cn_d.tl = t200_q[lle_pkg::TIMER_BITS-1:0];
            cn_d.tr = 1'b1;
          end
        end
        lle_pkg::EV_RELREQ: begin
          if (ls_q != lle_pkg::ST_REL) begin
            cn_d  = '0;
            est_d = 1'b0;
            ls_d  = lle_pkg::ST_AREL;
            sh_d  = {1'b1, 6'd0, 3'd0, 3'd0, lle_pkg::FT_DISC};
            lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_DISC, side_q,
              1'b1, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
            cn_d.tl = t200_q[lle_pkg::TIMER_BITS-1:0];
            cn_d.tr = 1'b1;
          end
        end
        lle_pkg::EV_ERR: abn = 1'b1;
        lle_pkg::EV_HARD: begin
          cn_d = '0; rel = 1'b1; rind = lle_pkg::IND_HARD;
        end
        lle_pkg::EV_SEG: begin
          if (ls_q == lle_pkg::ST_REL) begin
            abn = 1'b1;
          end else if ((ls_q != lle_pkg::ST_EST && ls_q != lle_pkg::ST_CONT) ||
                       cn_q.sc != cn_q.ac) begin
            lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_BUSY, 3'd0, 1'b0, 1'b0,
              3'd0, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
          end else begin
            if (ev_i.length > n201_q) begin
              seg_len  = n201_q;
              seg_more = 1'b1;
            end
            cn_d.sc = cn_q.sc + 3'd1;
            sh_d = {seg_more, seg_len, cn_q.sc, cn_q.rc, lle_pkg::FT_I};
            lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_I, side_q,
              1'b0, cn_q.rc, cn_q.sc, seg_len, seg_more, 1'b0, 3'd0));
            cn_d.tl = t200_q[lle_pkg::TIMER_BITS-1:0];
            cn_d.tr = 1'b1;
          end
        end
        default: ;
      endcase

      // abnormal release: error, DM F=1, L1 error, then a full release
      if (abn) begin
        lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_IND, 3'd0, 1'b0, 1'b0,
          3'd0, 3'd0, 6'd0, 1'b0, 1'b0, lle_pkg::IND_ERR));
        lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_SEND, lle_pkg::FT_DM, rsp,
          1'b1, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
        lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_L1ERR, 3'd0, 1'b0, 1'b0,
          3'd0, 3'd0, 6'd0, 1'b0, 1'b0, 3'd0));
        cn_d = '0;
        rel  = 1'b1;
      end
      if (rel) begin
        ls_d  = lle_pkg::ST_REL;
        est_d = 1'b0;
        if (sapi_q == 2'd0)
          lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_L1REL, 3'd0, 1'b0, 1'b0,
            3'd0, 3'd0, 6'd0, 1'b0, 1'b0, rind));
        lst = lle_pkg::push(lst, lle_pkg::mk(lle_pkg::ACT_IND, 3'd0, 1'b0, 1'b0,
          3'd0, 3'd0, 6'd0, 1'b0, 1'b0, rind));
      end
    end
  end

  logic res_last;
  assign res_last         = ({1'b0, idx_q} + 4'd1) == lst_q.n;
  assign res_valid_o      = busy_q && !res_full_i;
  assign res_o.r          = lst_q.e[idx_q];
  assign res_o.link_state = ls_q;
  assign res_o.last       = res_last;

  always_ff @(posedge clk_i) begin
    if (ev_take_o) begin
      lst_q <= lst;
      sh_q  <= sh_d;
      cv_q  <= cv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sapi_q <= 2'd0;
      side_q <= 1'b0;
      t200_q <= 16'd900;
      n200_q <= 8'd23;
      n201_q <= 6'd20;
      ls_q   <= lle_pkg::ST_REL;
      est_q  <= 1'b0;
      cn_q   <= '0;
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          lle_pkg::CFG_SAPI: sapi_q <= cfg_data_i[1:0];
          lle_pkg::CFG_SIDE: side_q <= cfg_data_i[0];
          lle_pkg::CFG_T200: t200_q <= cfg_data_i;
          lle_pkg::CFG_N200: n200_q <= cfg_data_i[7:0];
          lle_pkg::CFG_N201: n201_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (ev_take_o) begin
        ls_q   <= ls_d;
        est_q  <= est_d;
        cn_q   <= cn_d;
        busy_q <= (lst.n != 4'd0);
        idx_q  <= 3'd0;
      end else if (res_valid_o) begin
        // advance through the buffered list, drop busy after the last entry
        idx_q <= idx_q + 3'd1;
        if (res_last) busy_q <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/lle_outq.sv
// ----------------------------------------------------------------------------
// lle_outq
// Result queue toward the receiver: push from the engine, pop by the user.
// ----------------------------------------------------------------------------
module lle_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  lle_pkg::out_t  data_i,
  output logic           full_o,
  output logic           empty,
  input  logic           pop,
  output lle_pkg::out_t  data_o
);

  lle_pkg::out_t mem [lle_pkg::OUTQ_DEPTH];
  logic [1:0]    wp_q, rp_q;
  logic [2:0]    cnt_q, cnt_d;
  logic          rd;

  assign full_o = (cnt_q == 3'(lle_pkg::OUTQ_DEPTH));
  assign empty  = (cnt_q == 3'd0);
  assign rd     = pop && !empty;
  assign data_o = mem[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i) cnt_d = cnt_d + 3'd1;
    if (rd)   cnt_d = cnt_d - 3'd1;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 2'd0;
      rp_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      if (wr_i) wp_q <= wp_q + 2'd1;
      if (rd)   rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_d;
    end
  end

endmodule

### hw/rtl/lapdm_link_engine_checker.sv
// ----------------------------------------------------------------------------
// lapdm_link_engine_checker
// Port-level checks of the link engine, bound to the top level.
// ----------------------------------------------------------------------------
module lapdm_link_engine_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic       cfg_ready_o,
  input logic [2:0] action_o,
  input logic [2:0] indication_o,
  input logic [2:0] link_state_out_o,
  input logic       last_o
);

  // A waiting result holds until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(action_o) && $stable(last_o)))
    else $error("result changed while stalled");

  // Busy status is always the only result of its request.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && action_o == lle_pkg::ACT_BUSY) |-> last_o)
    else $error("busy result not alone");

  // An L1 release carries a release or hard release indication.
  a_l1rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && action_o == lle_pkg::ACT_L1REL) |->
    (indication_o == lle_pkg::IND_REL || indication_o == lle_pkg::IND_HARD))
    else $error("L1 release with wrong indication");

  // A release always leaves the link released.
  a_relstate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && action_o == lle_pkg::ACT_L1REL) |-> (link_state_out_o == lle_pkg::ST_REL))
    else $error("release without released state");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config port not ready");

endmodule

bind lapdm_link_engine lapdm_link_engine_checker u_checker (
  .clk_i, .rst_ni, .empty, .pop, .cfg_ready_o, .action_o, .indication_o,
  .link_state_out_o, .last_o
);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LAPDm link engine: a queue-fed driver, a
// result monitor and a cycle-free link predictor compared result by result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lle_pkg::*;

  // one event as offered on the input queue
  typedef struct {
    logic [3:0]  cmd;
    logic [1:0]  fmt;
    logic [2:0]  uk;
    logic [1:0]  sk;
    logic        pf;
    logic        cr;
    logic [2:0]  ns;
    logic [2:0]  nr;
    logic        more;
    logic [5:0]  len;
    logic [15:0] sum;
  } link_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        req_push = 1'b0;
  logic        req_full;
  link_req_t   drv = '{default: '0};
  logic        res_empty;
  logic        res_pop = 1'b0;
  logic [2:0]  action, frame_type, nr_out, ns_out, indication, link_state_out;
  logic        address_cr, poll_final_out, more_out, echo_payload, last_flag;
  logic [5:0]  length_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  lapdm_link_engine uut (
    .clk_i(clk), .rst_ni(rst_n),
    .push(req_push), .full(req_full),
    .command_i(drv.cmd), .frame_format_i(drv.fmt), .u_kind_i(drv.uk), .s_kind_i(drv.sk),
    .poll_final_in_i(drv.pf), .cr_in_i(drv.cr), .ns_in_i(drv.ns), .nr_in_i(drv.nr),
    .more_in_i(drv.more), .length_in_i(drv.len), .payload_sum_i(drv.sum),
    .empty(res_empty), .pop(res_pop),
    .action_o(action), .frame_type_o(frame_type), .address_cr_o(address_cr),
    .poll_final_out_o(poll_final_out), .nr_out_o(nr_out), .ns_out_o(ns_out),
    .length_out_o(length_out), .more_out_o(more_out), .echo_payload_o(echo_payload),
    .indication_o(indication), .link_state_out_o(link_state_out), .last_o(last_flag),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  initial forever #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Link predictor: shadow configuration and link state
  // --------------------------------------------------------------------------
  logic [1:0]  c_sapi = 2'd0;
  logic        c_side = 1'b0;
  logic [15:0] c_t200 = 16'd900;
  logic [7:0]  c_n200 = 8'd23;
  logic [5:0]  c_n201 = 6'd20;

  logic [2:0]  lk_state = ST_REL;
  logic [2:0]  vs = '0, va = '0, vr = '0;
  logic [7:0]  retries = '0;
  logic [15:0] t_left = '0;
  logic        t_run = 1'b0, est_flag = 1'b0, seg_pend = 1'b0;
  logic [15:0] cont_sum = '0;
  logic [15:0] held_hdr = '0;   // header awaiting acknowledgement

  res_t        step_res[$];      // results of the event being predicted
  out_t        awaited_res[$];   // predicted results not yet popped
  link_req_t   pending_req[$];   // events not yet accepted by the block

  int errors = 0, n_events = 0, n_checked = 0, n_busy = 0, n_retx = 0;
  bit idle_mode = 1'b0;

  function automatic void put(input logic [2:0] act, input logic [2:0] ft,
                              input logic cr, input logic pf, input logic [2:0] nr,
                              input logic [2:0] ns, input logic [5:0] len,
                              input logic more, input logic echo, input logic [2:0] ind);
    res_t r;
    if (step_res.size() >= MAX_RES) return;
    r.action = act; r.frame_type = ft; r.address_cr = cr; r.poll_final = pf;
    r.nr = nr; r.ns = ns; r.length = len; r.more = more; r.echo = echo;
    r.indication = ind;
    step_res.push_back(r);
  endfunction

  function automatic void tell_upper(input logic [2:0] ind);
    put(ACT_IND, FT_I, 1'b0, 1'b0, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, ind);
  endfunction

  // responses carry the inverse of our own command bit
  function automatic void respond(input logic [2:0] ft, input logic pf, input logic [2:0] nr,
                                  input logic [5:0] len, input logic echo);
    put(ACT_SEND, ft, ~c_side, pf, nr, 3'd0, len, 1'b0, echo, IND_EST);
  endfunction

  function automatic void arm_t200();
    t_left = c_t200;
    t_run = 1'b1;
  endfunction

  // send a frame that needs acknowledgement and keep its header for retransmit
  function automatic void send_held(input logic [2:0] ft, input logic pf, input logic [2:0] nr,
                                    input logic [2:0] ns, input logic [5:0] len,
                                    input logic more);
    held_hdr = {(ft == FT_I) ? more : pf, len, ns, nr, ft};
    put(ACT_SEND, ft, c_side, pf, nr, ns, len, more, 1'b0, IND_EST);
    arm_t200();
  endfunction

  function automatic void wipe_counters();
    t_run = 1'b0; t_left = '0;
    vs = '0; va = '0; vr = '0; retries = '0; seg_pend = 1'b0;
  endfunction

  function automatic void drop_link(input logic [2:0] ind);
    lk_state = ST_REL;
    est_flag = 1'b0;
    if (c_sapi == 2'd0)
      put(ACT_L1REL, FT_I, 1'b0, 1'b0, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, ind);
    tell_upper(ind);
  endfunction

  function automatic void full_release(input logic [2:0] ind);
    wipe_counters();
    drop_link(ind);
  endfunction

  function automatic void abort_link();
    tell_upper(IND_ERR);
    respond(FT_DM, 1'b1, 3'd0, 6'd0, 1'b0);
    put(ACT_L1ERR, FT_I, 1'b0, 1'b0, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, IND_EST);
    full_release(IND_REL);
  endfunction

  function automatic void take_ack(input logic [2:0] nr);
    va = nr;
    if (va == vs) begin
      retries = '0; t_run = 1'b0; t_left = '0;
    end
  endfunction

  function automatic void t200_fired();
    logic [2:0] ft;
    logic       b;
    ft = held_hdr[2:0];
    b  = held_hdr[15];
    t_run = 1'b0; t_left = '0;
    if (lk_state == ST_AREL) begin
      drop_link(IND_REL);
      return;
    end
    if (lk_state != ST_CONT && lk_state != ST_EST && lk_state != ST_AEST) return;
    if (retries > c_n200) begin
      abort_link();
      return;
    end
    if (retries != 8'd255) retries++;
    put(ACT_RETX, ft, c_side, (ft == FT_I) ? 1'b0 : b, held_hdr[5:3], held_hdr[8:6],
        held_hdr[14:9], (ft == FT_I) ? b : 1'b0, 1'b0, IND_EST);
    arm_t200();
  endfunction

  function automatic void got_sabm(input link_req_t q);
    if (!q.pf) return;
    case (lk_state)
      ST_REL: begin
        wipe_counters();
        est_flag = 1'b1;
        tell_upper(IND_EST);
        if (q.len != 0) begin
          lk_state = ST_CONT;
          cont_sum = q.sum;
          tell_upper(IND_LAST);
          respond(FT_UA, 1'b1, 3'd0, q.len, 1'b1);
        end else begin
          lk_state = ST_EST;
          respond(FT_UA, 1'b1, 3'd0, 6'd0, 1'b0);
        end
      end
      ST_CONT: begin
        if (q.sum == cont_sum) begin
          lk_state = ST_EST;
          respond(FT_UA, 1'b1, 3'd0, q.len, q.len != 0);
        end
      end
      ST_AEST: respond(FT_UA, 1'b1, 3'd0, 6'd0, 1'b0);
      ST_AREL: respond(FT_DM, 1'b1, 3'd0, 6'd0, 1'b0);
      default: begin
        if (est_flag) respond(FT_UA, 1'b1, 3'd0, q.len, q.len != 0);
        else if (q.len != 0) abort_link();
        else begin
          respond(FT_UA, 1'b1, 3'd0, 6'd0, 1'b0);
          wipe_counters();
        end
      end
    endcase
  endfunction

  function automatic void got_u(input link_req_t q);
    case (q.uk)
      U_SABM: got_sabm(q);
      U_DM: if (lk_state != ST_REL && q.pf) full_release(IND_REL);
      U_UI: if (q.len != 0) tell_upper(IND_UNIT);
      U_DISC: begin
        est_flag = 1'b0;
        if (lk_state == ST_AEST) full_release(IND_REL);
        else if (lk_state == ST_REL) begin
          respond(FT_DM, q.pf, 3'd0, 6'd0, 1'b0);
          full_release(IND_REL);
        end else if (lk_state == ST_AREL) respond(FT_UA, q.pf, 3'd0, 6'd0, 1'b0);
        else begin
          respond(FT_UA, q.pf, 3'd0, 6'd0, 1'b0);
          full_release(IND_REL);
        end
      end
      U_UA: begin
        if (!q.pf) abort_link();
        else if (lk_state == ST_AEST) begin
          wipe_counters();
          lk_state = ST_EST;
          tell_upper(IND_EST);
        end else if (lk_state == ST_AREL) full_release(IND_REL);
        else if (lk_state != ST_EST) abort_link();
      end
      default: abort_link();
    endcase
  endfunction

  function automatic void got_s(input link_req_t q);
    est_flag = 1'b0;
    if (q.sk == S_RR) begin
      if (lk_state == ST_CONT) lk_state = ST_EST;
      if (lk_state != ST_EST) return;
      if (q.cr == c_side && q.pf) respond(FT_RR, 1'b1, vr, 6'd0, 1'b0);
      take_ack(q.nr);
    end else if (q.sk == S_REJ) begin
      if (lk_state == ST_CONT) lk_state = ST_EST;
      if (lk_state == ST_EST) begin
        take_ack(q.nr);
        if (q.pf) begin
          if (q.cr != c_side) respond(FT_RR, 1'b1, vr, 6'd0, 1'b0);
          else begin
            abort_link();
            return;
          end
        end
        put(ACT_IDLE, FT_UI, c_side, 1'b0, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, IND_EST);
      end
      put(ACT_IDLE, FT_UI, c_side, 1'b0, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, IND_EST);
    end else abort_link();
  endfunction

  function automatic void got_i(input link_req_t q);
    est_flag = 1'b0;
    if (lk_state == ST_CONT) lk_state = ST_EST;
    if (lk_state != ST_EST) return;
    take_ack(q.nr);
    if (q.ns == vr) begin
      vr = vr + 3'd1;
      seg_pend = q.more;
      tell_upper(q.more ? IND_SEG : IND_LAST);
      respond(FT_RR, q.pf, vr, 6'd0, 1'b0);
    end else respond(FT_REJ, q.pf, vr, 6'd0, 1'b0);
  endfunction

  function automatic void send_seg(input link_req_t q);
    logic [5:0] len;
    logic       more;
    logic [2:0] ns;
    len = q.len;
    more = q.more;
    if (lk_state == ST_REL) begin
      abort_link();
      return;
    end
    if ((lk_state != ST_EST && lk_state != ST_CONT) || vs != va) begin
      put(ACT_BUSY, FT_I, 1'b0, 1'b0, 3'd0, 3'd0, 6'd0, 1'b0, 1'b0, IND_EST);
      return;
    end
    // clip an oversized segment and mark more to follow
    if (len > c_n201) begin
      len = c_n201;
      more = 1'b1;
    end
    ns = vs;
    vs = vs + 3'd1;
    send_held(FT_I, 1'b0, vr, ns, len, more);
  endfunction

  // advance the link by one event and queue the results it causes
  function automatic void predict_event(input link_req_t q);
    out_t o;
    step_res.delete();
    case (q.cmd)
      CMD_FRAME: begin
        if (q.fmt == FMT_I) got_i(q);
        else if (q.fmt == FMT_S) got_s(q);
        else if (q.fmt == FMT_U) got_u(q);
      end
      CMD_L1EST: wipe_counters();
      CMD_HO:    tell_upper(IND_HO);
      CMD_TICK: begin
        if (t_run) begin
          if (t_left <= 16'd1) t200_fired();
          else t_left--;
        end
      end
      CMD_ESTREQ: begin
        if (lk_state != ST_EST) begin
          wipe_counters();
          lk_state = ST_AEST;
          send_held(FT_SABM, 1'b1, 3'd0, 3'd0, 6'd0, 1'b0);
        end
      end
      CMD_RELREQ: begin
        if (lk_state != ST_REL) begin
          wipe_counters();
          est_flag = 1'b0;
          lk_state = ST_AREL;
          send_held(FT_DISC, 1'b1, 3'd0, 3'd0, 6'd0, 1'b0);
        end
      end
      CMD_ERR:  abort_link();
      CMD_HARD: full_release(IND_HARD);
      CMD_SEG:  send_seg(q);
      default: ;
    endcase
    foreach (step_res[i]) begin
      o.r = step_res[i];
      o.link_state = lk_state;
      o.last = (i == step_res.size() - 1);
      if (o.r.action == ACT_BUSY) n_busy++;
      if (o.r.action == ACT_RETX) n_retx++;
      awaited_res.push_back(o);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer pending requests, in idle mode with a random hold-off before each one
  // --------------------------------------------------------------------------
  int push_wait = 0;

  always @(posedge clk) begin
    logic nxt_push;
    nxt_push = 1'b0;
    if (rst_n) begin
      if (req_push && !req_full) begin
        predict_event(pending_req[0]);
        void'(pending_req.pop_front());
        n_events++;
        push_wait = idle_mode ? $urandom_range(0, 10) : 0;
      end
      if (push_wait > 0) push_wait--;
      else if (pending_req.size() > 0) begin
        drv <= pending_req[0];
        nxt_push = 1'b1;
      end
    end
    req_push <= nxt_push;
  end

  // --------------------------------------------------------------------------
  // Monitor: take results, with random stalls in idle mode, compare with the oldest forecast
  // --------------------------------------------------------------------------
  int pop_wait = 0;

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_t e;
    logic nxt_pop;
    nxt_pop = 1'b0;
    if (rst_n) begin
      if (res_pop && !res_empty) begin
        if (awaited_res.size() == 0) begin
          $error("unexpected result: action %0d frame_type %0d", action, frame_type);
          errors++;
        end else begin
          e = awaited_res.pop_front();
          n_checked++;
          check_field("action", e.r.action, action);
          check_field("frame_type", e.r.frame_type, frame_type);
          check_field("address_cr", e.r.address_cr, address_cr);
          check_field("poll_final_out", e.r.poll_final, poll_final_out);
          check_field("nr_out", e.r.nr, nr_out);
          check_field("ns_out", e.r.ns, ns_out);
          check_field("length_out", e.r.length, length_out);
          check_field("more_out", e.r.more, more_out);
          check_field("echo_payload", e.r.echo, echo_payload);
          check_field("indication", e.r.indication, indication);
          check_field("link_state_out", e.link_state, link_state_out);
          check_field("last", e.last, last_flag);
        end
        pop_wait = idle_mode ? $urandom_range(0, 10) : 0;
      end
      if (pop_wait > 0) pop_wait--;
      else nxt_pop = 1'b1;
    end
    res_pop <= nxt_pop;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic link_req_t any_req();
    link_req_t q;
    q.cmd = 4'($urandom_range(0, 15)); q.fmt = 2'($urandom_range(0, 3));
    q.uk = 3'($urandom_range(0, 7));   q.sk = 2'($urandom_range(0, 3));
    q.pf = 1'($urandom_range(0, 1));   q.cr = 1'($urandom_range(0, 1));
    q.ns = 3'($urandom_range(0, 7));   q.nr = 3'($urandom_range(0, 7));
    q.more = 1'($urandom_range(0, 1)); q.len = 6'($urandom_range(0, 63));
    q.sum = 16'($urandom_range(0, 65535));
    return q;
  endfunction

  function automatic link_req_t mk_req(input logic [3:0] cmd, input logic [1:0] fmt,
                                       input logic [2:0] uk, input logic [1:0] sk,
                                       input logic pf, input logic [5:0] len);
    link_req_t q;
    q = any_req();
    q.cmd = cmd; q.fmt = fmt; q.uk = uk; q.sk = sk; q.pf = pf; q.len = len;
    return q;
  endfunction

  // pick a plausible next event from the current link state; some noise
  function automatic link_req_t next_req();
    link_req_t q;
    int r;
    q = any_req();
    r = $urandom_range(0, 99);
    if (r < 12) return q;
    if (t_run && r < 35) begin
      q.cmd = CMD_TICK;
      return q;
    end
    r = $urandom_range(0, 99);
    case (lk_state)
      ST_REL: begin
        if (r < 45) q.cmd = CMD_ESTREQ;
        else if (r < 80) begin
          q = mk_req(CMD_FRAME, FMT_U, U_SABM, 2'd0, 1'b1, (r < 60) ? 6'd0 : q.len);
        end else q.cmd = 4'($urandom_range(1, 8));
      end
      ST_AEST: begin
        if (r < 65) q = mk_req(CMD_FRAME, FMT_U, U_UA, 2'd0, 1'b1, q.len);
        else if (r < 80) q.cmd = CMD_SEG;
        else q = mk_req(CMD_FRAME, FMT_U, 3'($urandom_range(0, 4)), 2'd0, q.pf, q.len);
      end
      ST_AREL: begin
        if (r < 50) q = mk_req(CMD_FRAME, FMT_U, U_UA, 2'd0, 1'b1, q.len);
        else if (r < 70) q = mk_req(CMD_FRAME, FMT_U, U_DISC, 2'd0, q.pf, q.len);
        else q.cmd = 4'($urandom_range(4, 8));
      end
      ST_CONT: begin
        if (r < 40) begin
          q = mk_req(CMD_FRAME, FMT_U, U_SABM, 2'd0, 1'b1, q.len);
          if (r < 30) q.sum = cont_sum;
        end else if (r < 70) begin
          q = mk_req(CMD_FRAME, FMT_I, 3'd0, 2'd0, q.pf, q.len);
          q.ns = vr;
        end else q.cmd = CMD_SEG;
      end
      default: begin
        if (r < 28) begin
          q.cmd = CMD_SEG;
          if ($urandom_range(0, 3) != 0) q.len = 6'($urandom_range(0, c_n201));
        end else if (r < 55) begin
          q = mk_req(CMD_FRAME, FMT_I, 3'd0, 2'd0, q.pf, q.len);
          if ($urandom_range(0, 4) != 0) q.ns = vr;
          q.nr = ($urandom_range(0, 3) != 0) ? vs : va;
        end else if (r < 75) begin
          q = mk_req(CMD_FRAME, FMT_S, 3'd0, S_RR, q.pf, q.len);
          q.nr = vs;
        end else if (r < 82) begin
          q = mk_req(CMD_FRAME, FMT_S, 3'd0, S_REJ, q.pf, q.len);
          q.nr = vs;
        end else if (r < 88) q = mk_req(CMD_FRAME, FMT_U, U_UI, 2'd0, q.pf, q.len);
        else if (r < 92) q.cmd = CMD_HO;
        else if (r < 94) q.cmd = CMD_L1EST;
        else if (r < 97) q.cmd = CMD_RELREQ;
        else q = mk_req(CMD_FRAME, FMT_U, U_SABM, 2'd0, 1'b1, q.len);
      end
    endcase
    return q;
  endfunction

  // wait until the block has drained every request and result
  task automatic drain();
    wait (pending_req.size() == 0 && awaited_res.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SAPI: c_sapi = val[1:0];
      CFG_SIDE: c_side = val[0];
      CFG_T200: c_t200 = val;
      CFG_N200: c_n200 = val[7:0];
      CFG_N201: c_n201 = val[5:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  typedef struct {
    logic [1:0]  sapi;
    logic        side;
    logic [15:0] t200;
    logic [7:0]  n200;
    logic [5:0]  n201;
  } link_cfg_t;

  link_cfg_t phases[5] = '{
    '{2'd0, 1'b0, 16'd1,     8'd0,   6'd1},
    '{2'd3, 1'b1, 16'd3,     8'd255, 6'd63},
    '{2'd1, 1'b1, 16'd0,     8'd2,   6'd20},
    '{2'd2, 1'b0, 16'd65535, 8'd5,   6'd10},
    '{2'd0, 1'b1, 16'd4,     8'd1,   6'd30}
  };

  initial begin
    link_req_t q;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening at reset configuration
    pending_req.push_back(mk_req(CMD_SEG, FMT_I, 3'd0, 2'd0, 1'b0, 6'd5));  // on released link
    pending_req.push_back(mk_req(CMD_ESTREQ, FMT_I, 3'd0, 2'd0, 1'b0, 6'd0));
    pending_req.push_back(mk_req(CMD_SEG, FMT_I, 3'd0, 2'd0, 1'b0, 6'd5));  // busy
    pending_req.push_back(mk_req(CMD_FRAME, FMT_U, U_UA, 2'd0, 1'b1, 6'd0));
    pending_req.push_back(mk_req(CMD_SEG, FMT_I, 3'd0, 2'd0, 1'b0, 6'd63)); // oversized
    pending_req.push_back(mk_req(CMD_SEG, FMT_I, 3'd0, 2'd0, 1'b0, 6'd0));  // ack pending
    q = mk_req(CMD_FRAME, FMT_S, 3'd0, S_RR, 1'b1, 6'd0);
    q.nr = 3'd1; q.cr = 1'b0;
    pending_req.push_back(q);
    q = mk_req(CMD_FRAME, FMT_I, 3'd0, 2'd0, 1'b1, 6'd63);
    q.ns = 3'd0; q.nr = 3'd1; q.more = 1'b1;
    pending_req.push_back(q);
    q.ns = 3'd1; q.more = 1'b0;
    pending_req.push_back(q);
    q.ns = 3'd7;                                                             // out of sequence
    pending_req.push_back(q);
    pending_req.push_back(mk_req(CMD_FRAME, FMT_U, U_UI, 2'd0, 1'b0, 6'd0));
    pending_req.push_back(mk_req(CMD_FRAME, FMT_U, U_UI, 2'd0, 1'b0, 6'd63));
    pending_req.push_back(mk_req(CMD_FRAME, FMT_I, 3'd0, 2'd3, 1'b0, 6'd0) );
    pending_req.push_back(mk_req(4'd9, FMT_I, 3'd0, 2'd0, 1'b0, 6'd0));      // dropped
    pending_req.push_back(mk_req(4'd15, FMT_I, 3'd0, 2'd0, 1'b0, 6'd0));     // dropped
    pending_req.push_back(mk_req(CMD_HO, FMT_I, 3'd0, 2'd0, 1'b0, 6'd0));
    pending_req.push_back(mk_req(CMD_L1EST, FMT_I, 3'd0, 2'd0, 1'b0, 6'd0));
    pending_req.push_back(mk_req(CMD_FRAME, FMT_S, 3'd0, 2'd2, 1'b0, 6'd0)); // unknown S
    q = mk_req(CMD_FRAME, FMT_U, U_SABM, 2'd0, 1'b1, 6'd9);                  // contention
    q.sum = 16'hFFFF;
    pending_req.push_back(q);
    pending_req.push_back(q);                                                // same sum resolves
    pending_req.push_back(mk_req(CMD_FRAME, FMT_U, U_UA, 2'd0, 1'b0, 6'd0)); // UA with F=0
    pending_req.push_back(mk_req(CMD_HARD, FMT_I, 3'd0, 2'd0, 1'b0, 6'd0));
    pending_req.push_back(mk_req(CMD_FRAME, FMT_U, U_DISC, 2'd0, 1'b1, 6'd0));
    pending_req.push_back(mk_req(CMD_FRAME, FMT_U, 3'd5, 2'd0, 1'b0, 6'd0)); // unknown U
    pending_req.push_back(mk_req(CMD_ERR, FMT_I, 3'd0, 2'd0, 1'b0, 6'd0));
    drain();

    // random phases, one configuration each, extremes included
    foreach (phases[p]) begin
      write_reg(CFG_SAPI, {14'd0, phases[p].sapi});
      write_reg(CFG_SIDE, {15'd0, phases[p].side});
      write_reg(CFG_T200, phases[p].t200);
      write_reg(CFG_N200, {8'd0, phases[p].n200});
      write_reg(CFG_N201, {10'd0, phases[p].n201});
      for (int k = 0; k < 36; k++) begin
        if (k % 12 == 0) idle_mode = 1'($urandom_range(0, 1));
        wait (pending_req.size() == 0);
        pending_req.push_back(next_req());
      end
      // hold the link open only until the next phase; release it cleanly
      wait (pending_req.size() == 0);
      pending_req.push_back(mk_req(CMD_HARD, FMT_I, 3'd0, 2'd0, 1'b0, 6'd0));
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d events over %0d configurations; %0d results checked,",
             n_events, $size(phases) + 1, n_checked);
    $display("including %0d busy replies and %0d retransmissions.", n_busy, n_retx);
    if (errors == 0 && awaited_res.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding.", awaited_res.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
